[src/crrs_pkg.sv]
// ----------------------------------------------------------------------------
// crrs_pkg
// Shared types and constants of the register RAM slave: command codes,
// configuration register indexes, bus constants and state encoding.
// ----------------------------------------------------------------------------
package crrs_pkg;

  localparam int unsigned DIGITS_PER_ROW = 16;
  localparam int unsigned ROW_W          = 4 * DIGITS_PER_ROW;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 6;
  localparam int unsigned ADDR_W         = 12;

  localparam logic [15:0] RAM_INSTR   = 16'h0AF8;
  localparam logic [3:0]  SUB_FIRST   = 4'd0;
  localparam logic [3:0]  SUB_LAST    = 4'd15;
  localparam int unsigned CS_STEP     = 120;
  localparam int unsigned CLEAR_SPAN  = 10;
  localparam int unsigned DEC_TENS    = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_SLOT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_CS    = 2'd1;

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_CLR_ONE = 3'd2,
    CMD_CLR_TEN = 3'd4
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

endpackage

[src/crrs_row_ram.sv]
// ----------------------------------------------------------------------------
// crrs_row_ram
// Row store: a synchronous RAM with registered read data, plus one valid
// flag per row. A row whose flag is clear reads as zero, so reset and the
// clear commands only touch the flags.
// ----------------------------------------------------------------------------
module crrs_row_ram #(
  parameter int unsigned ROWS = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic                          rd_en_i,
  input  logic                          clr_en_i,
  input  logic                          clr_ten_i,
  input  logic [$clog2(ROWS)-1:0]       addr_i,
  input  logic [crrs_pkg::ROW_W-1:0]    wdata_i,
  output logic [crrs_pkg::ROW_W-1:0]    rdata_o
);
  import crrs_pkg::*;

  localparam int unsigned IDX_W = $clog2(ROWS);
  localparam int unsigned LIM_W = IDX_W + 4;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROW_W-1:0] rd_q;
  logic             rd_vld_q;
  logic [ROWS-1:0]  vld_q;
  logic [ROWS-1:0]  vld_d;
  logic [LIM_W-1:0] clr_lim;

  assign clr_lim = LIM_W'(addr_i) + (clr_ten_i ? LIM_W'(CLEAR_SPAN) : LIM_W'(1));

  always_comb begin
    vld_d = vld_q;
    for (int i = 0; i < ROWS; i++) begin
      if (clr_en_i && (LIM_W'(i) >= LIM_W'(addr_i)) && (LIM_W'(i) < clr_lim)) begin
        vld_d[i] = 1'b0;
      end
    end
    if (wr_en_i) begin
      vld_d[addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (rd_en_i) begin
        rd_vld_q <= vld_q[addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[addr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

[src/calculator_register_ram_slave_top.sv]
// ----------------------------------------------------------------------------
// calculator_register_ram_slave_top
// Register RAM slave of a nibble-serial calculator bus: holds a window of
// 16-digit registers, decodes RAM commands off the IO bus and executes
// read, write and clear at the proper bus states.
// ----------------------------------------------------------------------------
// Each input word is one bus state; each yields exactly one result word.
// A bus state that executes a pending read holds off the next word while
// the row RAM returns its data, in the cycle after the address. A word is
// accepted only while the result register is empty or being emptied in the
// same cycle. Clears act only on the per-row valid flags, and reset needs
// no clearing pass: rows read as zero until written. Configuration (chip_slot
// at index 0, use_chip_select at index 1) is written through cfg_we_i and
// takes effect from the next word.
module calculator_register_ram_slave_top #(
  parameter int unsigned ROWS_PER_CHIP = 30
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [crrs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [crrs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [3:0]                      sub_state_i,
  input  logic                            write_phase_i,
  input  logic [crrs_pkg::ROW_W-1:0]      io_in_i,
  input  logic [15:0]                     instruction_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [crrs_pkg::ROW_W-1:0]      read_data_o,
  output logic                            read_valid_o
);
  import crrs_pkg::*;

  localparam int unsigned IDX_W = $clog2(ROWS_PER_CHIP);

  // Configuration
  logic [5:0]       chip_slot_q;
  logic             use_cs_q;

  // Command sequencing state
  logic             wait_first_q, wait_first_d;
  logic             wait_second_q, wait_second_d;
  logic             pend_q, pend_d;
  cmd_e             pend_cmd_q, pend_cmd_d;
  logic [IDX_W-1:0] pend_row_q, pend_row_d;

  state_e           state_q, state_d;

  // Result register
  logic             out_valid_q;
  logic [ROW_W-1:0] out_data_q;
  logic             out_rvalid_q;

  logic             accept;
  logic             at_exec, at_cmd;
  logic             do_read, do_write, do_clear, clr_ten;
  logic [ROW_W-1:0] ram_rdata;

  // Address decode off the IO bus
  logic [3:0]       dig_cmd, dig_units, dig_tens, dig_cs;
  logic [ADDR_W-1:0] addr, base, limit, offset;
  logic             hit, known_cmd;

  // --------------------------------------------------------------------------
  // Configuration write port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_slot_q <= '0;
      use_cs_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHIP_SLOT: chip_slot_q <= cfg_data_i;
        CFG_USE_CS:    use_cs_q    <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: one word at a time; a read waits in ST_READ for the RAM
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = !out_valid_q || out_ready_i;
      ST_READ: in_ready_o = 1'b0;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && do_read) state_d = ST_READ;
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Bus state decode
  // --------------------------------------------------------------------------
  assign at_exec = (sub_state_i == SUB_FIRST) && write_phase_i;
  assign at_cmd  = (sub_state_i == SUB_LAST) && !write_phase_i;

  assign do_read  = at_exec && pend_q && (pend_cmd_q == CMD_READ);
  assign do_clear = at_exec && pend_q &&
                    ((pend_cmd_q == CMD_CLR_ONE) || (pend_cmd_q == CMD_CLR_TEN));
  assign clr_ten  = pend_cmd_q == CMD_CLR_TEN;
  assign do_write = at_cmd && pend_q && (pend_cmd_q == CMD_WRITE);

  // Decimal address: tens, units, and optionally the chip-select digit
  assign dig_cmd   = io_in_i[3:0];
  assign dig_units = io_in_i[11:8];
  assign dig_tens  = io_in_i[15:12];
  assign dig_cs    = io_in_i[19:16];

  assign addr = ADDR_W'(dig_tens) * ADDR_W'(DEC_TENS) + ADDR_W'(dig_units)
              + (use_cs_q ? ADDR_W'(dig_cs) * ADDR_W'(CS_STEP) : '0);
  assign base   = ADDR_W'(chip_slot_q) * ADDR_W'(ROWS_PER_CHIP);
  assign limit  = base + ADDR_W'(ROWS_PER_CHIP);
  assign offset = addr - base;
  assign hit    = (addr >= base) && (addr < limit);
  assign known_cmd = (dig_cmd == 4'(CMD_READ)) || (dig_cmd == 4'(CMD_WRITE)) ||
                     (dig_cmd == 4'(CMD_CLR_ONE)) || (dig_cmd == 4'(CMD_CLR_TEN));

  always_comb begin
    wait_first_d  = wait_first_q;
    wait_second_d = wait_second_q;
    pend_d        = pend_q;
    pend_cmd_d    = pend_cmd_q;
    pend_row_d    = pend_row_q;
    if (accept) begin
      if (do_read || do_clear || do_write) begin
        pend_d = 1'b0;
      end
      if (at_cmd) begin
        // Latch a new command in this window; it replaces any pending one
        if (wait_second_q && hit && known_cmd) begin
          pend_d     = 1'b1;
          pend_cmd_d = cmd_e'(dig_cmd[2:0]);
          pend_row_d = offset[IDX_W-1:0];
        end
        wait_second_d = wait_first_q;
        wait_first_d  = instruction_i == RAM_INSTR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      wait_first_q  <= 1'b0;
      wait_second_q <= 1'b0;
      pend_q        <= 1'b0;
      pend_cmd_q    <= CMD_READ;
      pend_row_q    <= '0;
    end else begin
      state_q       <= state_d;
      wait_first_q  <= wait_first_d;
      wait_second_q <= wait_second_d;
      pend_q        <= pend_d;
      pend_cmd_q    <= pend_cmd_d;
      pend_row_q    <= pend_row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Row store
  // --------------------------------------------------------------------------
  crrs_row_ram #(
    .ROWS (ROWS_PER_CHIP)
  ) u_row_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept && do_write),
    .rd_en_i   (accept && do_read),
    .clr_en_i  (accept && do_clear),
    .clr_ten_i (clr_ten),
    .addr_i    (pend_row_q),
    .wdata_i   (io_in_i),
    .rdata_o   (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Result register: hold the word until taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_READ) begin
      out_valid_q <= 1'b1;
    end else if (accept && !do_read) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      out_data_q   <= ram_rdata;
      out_rvalid_q <= 1'b1;
    end else if (accept && !do_read) begin
      out_data_q   <= '0;
      out_rvalid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_data_q;
  assign read_valid_o = out_rvalid_q;

endmodule

[sim/crrs_bus_checker.sv]
// ----------------------------------------------------------------------------
// crrs_bus_checker
// Watches both channels and the configuration port of the register RAM
// slave, keeps its own copy of the register rows and the command decode,
// and compares every result word against the predicted bus drive.
// ----------------------------------------------------------------------------
module crrs_bus_checker
  import crrs_pkg::*;
#(
  parameter int unsigned ROWS_PER_CHIP = 30
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [3:0]            sub_state_i,
  input  logic                  write_phase_i,
  input  logic [ROW_W-1:0]      io_in_i,
  input  logic [15:0]           instruction_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [ROW_W-1:0]      read_data_i,
  input  logic                  read_valid_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           outstanding_o
);

  typedef logic [ROW_W-1:0] row_t;
  typedef struct packed {
    row_t data;
    logic valid;
  } bus_drive_t;

  row_t        rows_q [ROWS_PER_CHIP];
  logic        wait_first_q;
  logic        wait_second_q;
  logic        exec_pending_q;
  cmd_e        pending_cmd_q;
  int unsigned pending_row_q;
  logic [5:0]  chip_slot_q;
  logic        use_cs_q;
  bus_drive_t  expected_drive_q [$];

  function automatic int unsigned digit(input row_t bus, input int unsigned idx);
    return int'((bus >> (4 * idx)) & 64'hF);
  endfunction

  task automatic report_mismatch(input string what, input row_t got, input row_t want);
    $display("mismatch: %s got %h expected %h at %0t", what, got, want, $time);
    mismatch_count_o++;
  endtask

  // One bus state: execute whatever is pending and due, then walk the
  // command decode forward on a sub-state 15 write-phase-0 state.
  task automatic advance_bus(input logic [3:0] sub, input logic wp, input row_t io,
                             input logic [15:0] instr, output bus_drive_t drive);
    int unsigned addr;
    int unsigned base;
    int unsigned cmd;
    int unsigned k;
    drive = '0;
    if (sub == SUB_FIRST && wp) begin
      if (exec_pending_q) begin
        case (pending_cmd_q)
          CMD_CLR_ONE: begin
            rows_q[pending_row_q] = '0;
            exec_pending_q = 1'b0;
          end
          CMD_CLR_TEN: begin
            // stop at the last row of the chip
            for (k = 0; k < CLEAR_SPAN && pending_row_q + k < ROWS_PER_CHIP; k++)
              rows_q[pending_row_q + k] = '0;
            exec_pending_q = 1'b0;
          end
          CMD_READ: begin
            drive.data  = rows_q[pending_row_q];
            drive.valid = 1'b1;
            exec_pending_q = 1'b0;
          end
          default: ;
        endcase
      end
    end else if (sub == SUB_LAST && !wp) begin
      if (exec_pending_q && pending_cmd_q == CMD_WRITE) begin
        rows_q[pending_row_q] = io;
        exec_pending_q = 1'b0;
      end
      if (wait_second_q) begin
        addr = digit(io, 3) * DEC_TENS + digit(io, 2);
        cmd  = digit(io, 0);
        base = chip_slot_q * ROWS_PER_CHIP;
        if (use_cs_q)
          addr += digit(io, 4) * CS_STEP;
        if (addr >= base && addr < base + ROWS_PER_CHIP &&
            (cmd == CMD_READ || cmd == CMD_WRITE || cmd == CMD_CLR_ONE ||
             cmd == CMD_CLR_TEN)) begin
          pending_row_q  = addr - base;
          pending_cmd_q  = cmd_e'(cmd[2:0]);
          exec_pending_q = 1'b1;
        end
        wait_second_q = 1'b0;
      end
      if (wait_first_q) begin
        wait_first_q  = 1'b0;
        wait_second_q = 1'b1;
      end
      if (instr == RAM_INSTR)
        wait_first_q = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bus_drive_t want;
    bus_drive_t next_drive;
    if (!rst_ni) begin
      foreach (rows_q[i]) rows_q[i] = '0;
      wait_first_q     = 1'b0;
      wait_second_q    = 1'b0;
      exec_pending_q   = 1'b0;
      pending_cmd_q    = CMD_READ;
      pending_row_q    = 0;
      chip_slot_q      = '0;
      use_cs_q         = 1'b0;
      mismatch_count_o = 0;
      expected_drive_q.delete();
    end else begin
      // results first: a result word never belongs to a word taken at this edge
      if (out_valid_i && out_ready_i) begin
        if (expected_drive_q.size() == 0) begin
          report_mismatch("unexpected result word", read_data_i, '0);
        end else begin
          want = expected_drive_q.pop_front();
          if (read_valid_i !== want.valid)
            report_mismatch("read_valid", row_t'(read_valid_i), row_t'(want.valid));
          if (read_data_i !== want.data)
            report_mismatch("read_data", read_data_i, want.data);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CHIP_SLOT: chip_slot_q = cfg_data_i;
          CFG_USE_CS:    use_cs_q    = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        advance_bus(sub_state_i, write_phase_i, io_in_i, instruction_i, next_drive);
        expected_drive_q.push_back(next_drive);
      end
    end
    outstanding_o = expected_drive_q.size();
  end

endmodule

[sim/calculator_register_ram_slave_top_tb.sv]
// ----------------------------------------------------------------------------
// calculator_register_ram_slave_top_tb
// Drives bus states into the register RAM slave: a short directed run over
// write, clear-ten at the top of the chip, read and unknown commands, then
// randomised RAM accesses across several window and chip-select settings.
// A separate checker predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module calculator_register_ram_slave_top_tb;
  import crrs_pkg::*;

  localparam int unsigned ROWS            = 30;
  localparam int unsigned MAX_DECIMAL     = 15 * DEC_TENS + 15;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned WORDS_PER_PHASE = 84;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam logic [3:0]  CMD_NONE        = 4'hF;

  typedef logic [ROW_W-1:0] row_t;
  typedef enum int unsigned { RX_ALWAYS, RX_RANDOM, RX_PATTERN } rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [3:0]            sub_state_i;
  logic                  write_phase_i;
  row_t                  io_in_i;
  logic [15:0]           instruction_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  row_t                  read_data_o;
  logic                  read_valid_o;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycles;
  int unsigned burst_left;
  int unsigned bus_words;
  int unsigned rx_left;
  rx_mode_e    rx_mode;
  logic [7:0]  rx_pattern;

  calculator_register_ram_slave_top #(
    .ROWS_PER_CHIP(ROWS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sub_state_i  (sub_state_i),
    .write_phase_i(write_phase_i),
    .io_in_i      (io_in_i),
    .instruction_i(instruction_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .read_valid_o (read_valid_o)
  );

  crrs_bus_checker #(
    .ROWS_PER_CHIP(ROWS)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .sub_state_i     (sub_state_i),
    .write_phase_i   (write_phase_i),
    .io_in_i         (io_in_i),
    .instruction_i   (instruction_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_data_i     (read_data_o),
    .read_valid_i    (read_valid_o),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bound the run: a hung handshake ends here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: stall on a pattern of its own, in segments that are
  // either always ready, randomly ready or following a rotating bit pattern.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode    = rx_mode_e'($urandom_range(0, 2));
      rx_left    = $urandom_range(16, 160);
      rx_pattern = 8'($urandom_range(1, 255));
    end
    rx_left--;
    case (rx_mode)
      RX_ALWAYS: out_ready_i <= 1'b1;
      RX_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: begin
        out_ready_i <= rx_pattern[0];
        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
      end
    endcase
  end

  function automatic logic [15:0] other_instr();
    logic [15:0] v;
    do v = 16'($urandom); while (v == RAM_INSTR);
    return v;
  endfunction

  // Build the IO word for a command: digit 0 the command, digits 3 and 2 the
  // decimal address, digit 4 the chip-select digit, weighted by 120. Vary the split over
  // digits where the sum allows it, so that digits above nine get used too.
  function automatic row_t command_bus(input logic [3:0] cmd, input int unsigned addr,
                                       input bit cs);
    row_t        bus;
    int unsigned hi;
    int unsigned rest;
    int unsigned tens;
    int unsigned ones;
    bus = {$urandom, $urandom};
    hi  = 0;
    if (cs) begin
      hi = addr / CS_STEP;
      if (hi > 15)
        hi = 15;
      if (hi > 0 && addr - hi * CS_STEP + CS_STEP <= MAX_DECIMAL && $urandom_range(0, 1))
        hi--;
      bus[19:16] = 4'(hi);
    end
    rest = addr - hi * CS_STEP;
    tens = rest / DEC_TENS;
    ones = rest % DEC_TENS;
    if (tens > 15 || (tens > 0 && ones < 6 && $urandom_range(0, 1))) begin
      tens--;
      ones += DEC_TENS;
    end
    bus[15:12] = 4'(tens);
    bus[11:8]  = 4'(ones);
    bus[3:0]   = cmd;
    return bus;
  endfunction

  // Offer one word; hold it until taken. Whenever a burst runs out, mostly open a gap.
  task automatic send_word(input logic [3:0] sub, input logic wp, input row_t io,
                           input logic [15:0] instr);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    sub_state_i   <= sub;
    write_phase_i <= wp;
    io_in_i       <= io;
    instruction_i <= instr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Bus states that neither execute nor decode anything.
  task automatic send_noise(input int unsigned n);
    logic [3:0] sub;
    logic       wp;
    repeat (n) begin
      do begin
        sub = 4'($urandom);
        wp  = 1'($urandom);
      end while ((sub == SUB_LAST && !wp) || (sub == SUB_FIRST && wp));
      send_word(sub, wp, {$urandom, $urandom}, 16'($urandom));
      bus_words++;
    end
  endtask

  // The RAM instruction followed by two more sub-state 15 words, the last
  // carrying command and address; drop a few idle states in between now and then.
  task automatic issue_command(input logic [3:0] cmd, input int unsigned addr, input bit cs);
    send_word(SUB_LAST, 1'b0, {$urandom, $urandom}, RAM_INSTR);
    if ($urandom_range(0, 5) == 0)
      send_noise($urandom_range(1, 3));
    send_word(SUB_LAST, 1'b0, {$urandom, $urandom}, other_instr());
    if ($urandom_range(0, 5) == 0)
      send_noise($urandom_range(1, 3));
    send_word(SUB_LAST, 1'b0, command_bus(cmd, addr, cs), other_instr());
    bus_words += 3;
  endtask

  // Drop valid and wait until every expected result word is back, then settle.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned slot_plan [PHASES];
    bit          cs_plan   [PHASES];
    int unsigned phase;
    int unsigned phase_start;
    int unsigned cur_slot;
    bit          cur_cs;
    int unsigned base;
    int unsigned reach;
    int unsigned addr;
    int unsigned pick;
    int unsigned exec_kind;
    logic [3:0]  cmd;
    row_t        data;
    bit          paused;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    sub_state_i   = '0;
    write_phase_i = 1'b0;
    io_in_i       = '0;
    instruction_i = '0;
    out_ready_i   = 1'b0;
    cycles        = 0;
    burst_left    = 0;
    bus_words     = 0;
    rx_left       = 0;
    paused        = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed run at reset settings (window 0, no chip select).
    // Fill the last row with ones, clear ten from row 25 so the clear runs
    // into the end of the chip, then read the last row back as zero.
    issue_command({1'b0, CMD_WRITE}, ROWS - 1, 1'b0);
    send_word(SUB_LAST, 1'b0, '1, other_instr());
    issue_command({1'b0, CMD_CLR_TEN}, ROWS - 5, 1'b0);
    send_word(SUB_FIRST, 1'b1, '1, 16'hFFFF);
    issue_command({1'b0, CMD_READ}, ROWS - 1, 1'b0);
    send_word(SUB_FIRST, 1'b1, '0, 16'h0000);
    // Write row 0 with ones and an all-ones instruction, read it back.
    issue_command({1'b0, CMD_WRITE}, 0, 1'b0);
    send_word(SUB_LAST, 1'b0, '1, 16'hFFFF);
    issue_command({1'b0, CMD_READ}, 0, 1'b0);
    send_word(SUB_FIRST, 1'b1, '0, 16'h0000);
    // Unknown command: nothing becomes pending, the read state stays quiet.
    issue_command(CMD_NONE, 3, 1'b0);
    send_word(SUB_FIRST, 1'b1, '0, 16'h0000);

    slot_plan    = '{0, 5, 63, 63, 0, 1};
    cs_plan      = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    slot_plan[4] = $urandom_range(0, 63);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      cur_slot = slot_plan[phase];
      cur_cs   = cs_plan[phase];
      write_reg(CFG_CHIP_SLOT, CFG_DATA_W'(cur_slot));
      write_reg(CFG_USE_CS, CFG_DATA_W'(cur_cs));
      base        = cur_slot * ROWS;
      reach       = cur_cs ? 15 * CS_STEP + MAX_DECIMAL : MAX_DECIMAL;
      phase_start = bus_words;

      while (bus_words - phase_start < WORDS_PER_PHASE) begin
        // Once, halfway through phase 2, hold off until the slave has caught up.
        if (phase == 2 && !paused && bus_words - phase_start >= WORDS_PER_PHASE / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 9);

        // Broken sequence: one or two RAM instruction states and no command.
        if (pick == 9) begin
          repeat ($urandom_range(1, 2)) begin
            send_word(SUB_LAST, 1'b0, {$urandom, $urandom}, RAM_INSTR);
            bus_words++;
          end
          continue;
        end

        // Target: mostly inside the window, favouring the top rows, else outside.
        if (pick < 8 && base <= reach) begin
          addr = base + (($urandom_range(0, 3) == 0) ? $urandom_range(ROWS - 10, ROWS - 1)
                                                     : $urandom_range(0, ROWS - 1));
          if (addr > reach)
            addr = base + $urandom_range(0, reach - base);
        end else begin
          do addr = $urandom_range(0, reach); while (addr >= base && addr < base + ROWS);
        end

        if (pick == 7) begin
          do cmd = 4'($urandom);
          while (cmd == CMD_READ || cmd == CMD_WRITE || cmd == CMD_CLR_ONE ||
                 cmd == CMD_CLR_TEN);
        end else begin
          case ($urandom_range(0, 3))
            0:       cmd = {1'b0, CMD_READ};
            1:       cmd = {1'b0, CMD_WRITE};
            2:       cmd = {1'b0, CMD_CLR_ONE};
            default: cmd = {1'b0, CMD_CLR_TEN};
          endcase
        end
        issue_command(cmd, addr, cur_cs);

        if ($urandom_range(0, 2) == 0)
          send_noise($urandom_range(1, 3));

        // Execute at the proper state mostly; sometimes skip it so the next
        // command replaces this one, or offer the wrong state so it stays pending.
        data      = ($urandom_range(0, 7) == 0) ? '1 : {$urandom, $urandom};
        exec_kind = $urandom_range(0, 9);
        if (exec_kind == 0) begin
          continue;
        end else if ((exec_kind == 1) != (cmd == CMD_WRITE)) begin
          send_word(SUB_LAST, 1'b0, data,
                    ($urandom_range(0, 7) == 0) ? RAM_INSTR : other_instr());
        end else begin
          send_word(SUB_FIRST, 1'b1, data, 16'($urandom));
        end
        bus_words++;
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/crrs_pkg.sv
src/crrs_row_ram.sv
src/calculator_register_ram_slave_top.sv
sim/crrs_bus_checker.sv
sim/calculator_register_ram_slave_top_tb.sv
